[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers shared by the sieve rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define PCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define PCS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/pcs_pkg.sv]
// ---------------------------------------------------------------------------
// pcs_pkg
// shared widths and result type of the prime count sieve
// ---------------------------------------------------------------------------
package pcs_pkg;

  localparam int N_W         = 13;  // limit field width
  localparam int CNT_W       = 10;  // prime count field width
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic [CNT_W-1:0] prime_count;
    logic             out_of_range;
  } result_t;

endpackage

[rtl/pcs_bitmap.sv]
// ---------------------------------------------------------------------------
// pcs_bitmap
// one-bit composite map, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pcs_bitmap #(
  parameter int AW    = 13,
  parameter int DEPTH = 4097
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem_r [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/pcs_seq.sv]
// ---------------------------------------------------------------------------
// pcs_seq
// sieve sequencer: init pass, odd-multiple marking, count pass
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pcs_seq import pcs_pkg::*; #(
  parameter int MAX_N = 4096,
  parameter int AW    = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_i,
  input  logic [N_W-1:0] n_i,
  output logic           idle_o,
  output logic           res_vld_o,
  input  logic           res_take_i,
  output result_t        res_o,
  output logic           mem_we_o,
  output logic [AW-1:0]  mem_waddr_o,
  output logic           mem_wdata_o,
  output logic           mem_re_o,
  output logic [AW-1:0]  mem_raddr_o,
  input  logic           mem_rdata_i
);

  localparam int CW = AW + 1;
  localparam int SW = 2 * CW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_MARK_I,
    S_MARK_J,
    S_COUNT,
    S_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    lim_r, lim_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [SW-1:0]    sq_r, sq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             oor_r, oor_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    j_sum;
  logic             n_over;

  assign n_over = 32'(n_i) > 32'(MAX_N);
  assign j_sum  = j_r + i_r;

  always_comb begin
    state_nxt   = state_r;
    lim_nxt     = lim_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    sq_nxt      = sq_r;
    cnt_nxt     = cnt_r;
    oor_nxt     = oor_r;
    pend_nxt    = pend_r;
    mem_we_o    = 1'b0;
    mem_waddr_o = i_r[AW-1:0];
    mem_wdata_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = i_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          cnt_nxt   = '0;
          oor_nxt   = n_over;
          lim_nxt   = CW'(n_i);
          i_nxt     = '0;
          state_nxt = n_over ? S_RESULT : S_INIT;
        end
      end
      S_INIT: begin
        // 0 and 1 excluded, even numbers from 4 marked, rest cleared
        mem_we_o    = 1'b1;
        mem_wdata_o = (i_r < CW'(2)) || (!i_r[0] && (i_r >= CW'(4)));
        if (i_r == lim_r) begin
          i_nxt     = CW'(3);
          sq_nxt    = SW'(9);
          state_nxt = S_MARK_I;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      S_MARK_I: begin
        if (sq_r > SW'(lim_r)) begin
          i_nxt     = CW'(2);
          pend_nxt  = 1'b0;
          state_nxt = S_COUNT;
        end else begin
          j_nxt     = sq_r[CW-1:0];
          state_nxt = S_MARK_J;
        end
      end
      S_MARK_J: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = j_r[AW-1:0];
        mem_wdata_o = 1'b1;
        if (j_sum > lim_r) begin
          // (i+2)^2 = i^2 + 4i + 4
          sq_nxt    = sq_r + (SW'(i_r) << 2) + SW'(4);
          i_nxt     = i_r + CW'(2);
          state_nxt = S_MARK_I;
        end else begin
          j_nxt = j_sum;
        end
      end
      S_COUNT: begin
        if (i_r <= lim_r) begin
          mem_re_o = 1'b1;
          i_nxt    = i_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_RESULT;
          end
        end
        // read data is registered and arrives in the cycle after its address
        if (pend_r && !mem_rdata_i) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_RESULT: begin
        if (res_take_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    lim_r <= lim_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    sq_r  <= sq_nxt;
    cnt_r <= cnt_nxt;
    oor_r <= oor_nxt;
  end

  assign idle_o             = (state_r == S_IDLE);
  assign res_vld_o          = (state_r == S_RESULT);
  assign res_o.prime_count  = cnt_r;
  assign res_o.out_of_range = oor_r;

  `PCS_ASSERT(a_wr_in_limit, mem_we_o |-> ({1'b0, mem_waddr_o} <= lim_r), "map write past limit")
  `PCS_ASSERT(a_rd_in_count, mem_re_o |-> (state_r == S_COUNT) && (mem_raddr_o >= AW'(2)), "bad map read")
  `PCS_ASSERT(a_oor_no_count, res_vld_o && oor_r |-> (cnt_r == '0), "count on out-of-range limit")
  `PCS_NEVER(a_pend_outside, pend_r && (state_r != S_COUNT), "read pending outside count pass")

endmodule

[rtl/prime_count_sieve.sv]
// ---------------------------------------------------------------------------
// prime_count_sieve
// counts the primes in 2..n with a sieve of eratosthenes over a bitmap
// ---------------------------------------------------------------------------
// usage:
//   a request on the in_ channel carries the limit n in in_tdata[12:0].
//   one result comes back on the out_ channel per request: the prime count
//   in out_tdata[9:0] and the out-of-range flag in out_tuser[0].
//   a limit above MAX_N returns the flag with count 0 without any map pass.
//   otherwise the block runs three passes over the map memory, at most one
//   entry per cycle: clear/even init, marking of the multiples of every odd
//   i >= 3 with i*i <= n from i*i on, and a count pass over 2..n.
//   the single write port and registered read port of the map set the pace.
//   one request is worked at a time; in_tready is high while the sequencer
//   is idle, also when the last result still waits in the output register.
//   if out_tready stays low the finished result is held in the sequencer
//   until the output register frees up. synchronous active-low reset returns
//   to idle and drops out_tvalid; the map needs no clearing after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module prime_count_sieve import pcs_pkg::*; #(
  parameter int MAX_N = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [12:0] n_limit
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] prime_count
  output logic [0:0]             out_tuser   // [0] out_of_range
);

  localparam int AW = $clog2(MAX_N + 1);

  logic          idle;
  logic          res_vld;
  logic          res_take;
  result_t       res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;
  logic          out_valid_r, out_valid_nxt;
  result_t       out_res_r, out_res_nxt;

  pcs_seq #(
    .MAX_N (MAX_N),
    .AW    (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_tvalid),
    .n_i         (in_tdata[N_W-1:0]),
    .idle_o      (idle),
    .res_vld_o   (res_vld),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pcs_bitmap #(
    .AW    (AW),
    .DEPTH (MAX_N + 1)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register frees when empty or drained this cycle
  assign res_take = res_vld && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign in_tready    = idle;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_TDATA_W'(out_res_r.prime_count);
  assign out_tuser[0] = out_res_r.out_of_range;

  `PCS_NEVER(a_idle_with_result, idle && res_vld, "sequencer idle while holding a result")
  `PCS_ASSERT(a_load_from_seq, $rose(out_valid_r) |-> $past(res_take), "output loaded without a result")

endmodule
